/* rtl/core/xor_segment_tree_parity_assert.svh */
// assertion macros shared by the segment tree parity rtl
`ifndef XOR_SEGMENT_TREE_PARITY_ASSERT_SVH
`define XOR_SEGMENT_TREE_PARITY_ASSERT_SVH

// same-cycle implication, checked outside reset
`define XSTP_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define XSTP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/xstp_pkg.sv */
// shared types and constants of the segment tree parity block
`default_nettype none
package xstp_pkg;

    localparam int LOG_LEAVES = 10;
    localparam int LEAVES     = 1 << LOG_LEAVES;
    localparam int NODES      = 2 * LEAVES;
    localparam int NODE_W     = LOG_LEAVES + 1;
    localparam int BND_W      = LOG_LEAVES + 2;
    localparam int POS_W      = 10;
    localparam int END_W      = 11;

    localparam logic ACT_TOGGLE = 1'b0;
    localparam logic ACT_QUERY  = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_TG_LEAF,
        ST_TG_WALK,
        ST_QR_WALK,
        ST_QR_OUT
    } state_t;

    typedef struct packed {
        logic clear_step;
        logic load_toggle;
        logic load_query;
        logic tg_leaf;
        logic tg_walk;
        logic qr_step;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic in_range;
        logic tg_top;
        logic qr_busy;
    } dp_sts_t;

endpackage
`default_nettype wire

/* rtl/core/xor_segment_tree_parity.sv */
// top level of the xor segment tree: point toggle and range parity query
//
//  channel   dir   ports                                      beat
//  s_        in    s_valid s_ready s_action s_first_pos ...   one toggle or query
//  m_        out   m_valid m_ready m_parity                   one parity per query
//
// after reset a clear pass writes all 2048 tree nodes, one per cycle,
//   while s_ready stays low
// a toggle reads its leaf when accepted, then writes the flipped leaf and each tree level
//   up to the root in turn through the single memory write port
// a query walks up the tree level by level, reading both bounds through two read ports,
//   then drains the last reads and loads the output register
// a stalled result holds in the output register; the next item is accepted and
//   worked on, but its own result waits until the pending beat is taken
`default_nettype none
module xor_segment_tree_parity (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          s_valid,
    output logic                         s_ready,
    input  wire                          s_action,
    input  wire [xstp_pkg::POS_W-1:0]    s_first_pos,
    input  wire [xstp_pkg::END_W-1:0]    s_end_pos,
    input  wire                          s_flip,
    output logic                         m_valid,
    input  wire                          m_ready,
    output logic                         m_parity
);

    // command and status between sequencer and datapath
    xstp_pkg::dp_cmd_t cmd;
    xstp_pkg::dp_sts_t sts;

    // sequencer: clear pass, toggle walk, query walk, output handshake
    xstp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_action (s_action),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath: node memory with one write and two registered read ports
    xstp_dpath u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .first_pos (s_first_pos),
        .end_pos   (s_end_pos),
        .flip      (s_flip),
        .sts       (sts),
        .parity    (m_parity)
    );

endmodule
`default_nettype wire

/* rtl/core/xstp_dpath.sv */
// datapath: tree memory, clear counter, toggle walk and query walk registers
`default_nettype none
`include "xor_segment_tree_parity_assert.svh"
module xstp_dpath (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire xstp_pkg::dp_cmd_t       cmd,
    input  wire [xstp_pkg::POS_W-1:0]    first_pos,
    input  wire [xstp_pkg::END_W-1:0]    end_pos,
    input  wire                          flip,
    output xstp_pkg::dp_sts_t            sts,
    output logic                         parity
);

    localparam int NODE_W = xstp_pkg::NODE_W;
    localparam int BND_W  = xstp_pkg::BND_W;

    logic mem [0:xstp_pkg::NODES-1];

    logic [NODE_W-1:0] clr_cnt_reg;
    logic [NODE_W-1:0] node_reg;
    logic              cur_reg;
    logic              flip_reg;
    logic [BND_W-1:0]  lo_reg;
    logic [BND_W-1:0]  hi_reg;
    logic              acc_reg;
    logic              rd_a_en_reg;
    logic              rd_b_en_reg;
    logic              rdata_a_reg;
    logic              rdata_b_reg;
    logic              parity_reg;

    logic              in_range;
    logic [BND_W-1:0]  end_clamp;
    logic [BND_W-1:0]  lo_load;
    logic [NODE_W-1:0] leaf_node;
    logic [NODE_W-1:0] parent_node;
    logic [BND_W-1:0]  hi_m1;
    logic [BND_W-1:0]  lo_step;
    logic [BND_W-1:0]  hi_step;
    logic              qr_busy;
    logic              leaf_val;
    logic              par_val;
    logic              acc_next;
    logic [NODE_W-1:0] raddr_a;
    logic [NODE_W-1:0] raddr_b;
    logic              we;
    logic [NODE_W-1:0] waddr;
    logic              wdata;

    assign in_range    = 32'(first_pos) < xstp_pkg::LEAVES;
    assign end_clamp   = (32'(end_pos) > xstp_pkg::LEAVES) ? BND_W'(xstp_pkg::LEAVES)
                                                          : BND_W'(end_pos);
    assign lo_load     = in_range ? BND_W'(xstp_pkg::LEAVES) + BND_W'(first_pos)
                                  : BND_W'(xstp_pkg::LEAVES) + end_clamp;
    assign leaf_node   = NODE_W'(xstp_pkg::LEAVES) + NODE_W'(first_pos);
    assign parent_node = {1'b0, node_reg[NODE_W-1:1]};
    assign hi_m1       = hi_reg - BND_W'(1);
    assign lo_step     = (lo_reg + BND_W'(lo_reg[0])) >> 1;
    assign hi_step     = (hi_reg - BND_W'(hi_reg[0])) >> 1;
    assign qr_busy     = lo_reg < hi_reg;
    assign leaf_val    = rdata_a_reg ^ flip_reg;
    assign par_val     = cur_reg ^ rdata_a_reg;
    assign acc_next    = acc_reg ^ (rd_a_en_reg & rdata_a_reg) ^ (rd_b_en_reg & rdata_b_reg);

    // read and write address selection
    always_comb begin
        priority if (cmd.load_toggle) begin
            raddr_a = leaf_node;
        end else if (cmd.tg_leaf) begin
            raddr_a = node_reg ^ NODE_W'(1);
        end else if (cmd.tg_walk) begin
            raddr_a = parent_node ^ NODE_W'(1);
        end else begin
            raddr_a = lo_reg[NODE_W-1:0];
        end
        raddr_b = hi_m1[NODE_W-1:0];

        we    = 1'b0;
        waddr = clr_cnt_reg;
        wdata = 1'b0;
        priority if (cmd.clear_step) begin
            we = 1'b1;
        end else if (cmd.tg_leaf) begin
            we    = 1'b1;
            waddr = node_reg;
            wdata = leaf_val;
        end else if (cmd.tg_walk) begin
            we    = 1'b1;
            waddr = parent_node;
            wdata = par_val;
        end else begin
            we = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a_reg <= mem[raddr_a];
        rdata_b_reg <= mem[raddr_b];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
            rd_a_en_reg <= 1'b0;
            rd_b_en_reg <= 1'b0;
            acc_reg     <= 1'b0;
        end else begin
            if (cmd.clear_step) begin
                clr_cnt_reg <= clr_cnt_reg + NODE_W'(1);
            end
            if (cmd.load_query) begin
                rd_a_en_reg <= 1'b0;
                rd_b_en_reg <= 1'b0;
                acc_reg     <= 1'b0;
            end else begin
                rd_a_en_reg <= cmd.qr_step & qr_busy & lo_reg[0];
                rd_b_en_reg <= cmd.qr_step & qr_busy & hi_reg[0];
                acc_reg     <= acc_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_toggle) begin
            node_reg <= leaf_node;
            flip_reg <= flip;
        end else if (cmd.tg_leaf) begin
            cur_reg <= leaf_val;
        end else if (cmd.tg_walk) begin
            node_reg <= parent_node;
            cur_reg  <= par_val;
        end
        if (cmd.load_query) begin
            lo_reg <= lo_load;
            hi_reg <= BND_W'(xstp_pkg::LEAVES) + end_clamp;
        end else if (cmd.qr_step && qr_busy) begin
            lo_reg <= lo_step;
            hi_reg <= hi_step;
        end
        if (cmd.load_out) begin
            parity_reg <= acc_reg;
        end
    end

    assign sts.clear_last = &clr_cnt_reg;
    assign sts.in_range   = in_range;
    assign sts.tg_top     = (parent_node == NODE_W'(1));
    assign sts.qr_busy    = qr_busy;
    assign parity         = parity_reg;

    `XSTP_ASSERT_NEXT(a_lo_read_flag, aclk, aresetn,
        cmd.qr_step && qr_busy && lo_reg[0], rd_a_en_reg, "odd lower bound not read")
    `XSTP_ASSERT_SAME(a_walk_not_root, aclk, aresetn,
        cmd.tg_walk, node_reg > NODE_W'(1), "toggle walk above the root")
    `XSTP_ASSERT_SAME(a_query_bound, aclk, aresetn,
        cmd.qr_step && qr_busy, hi_reg <= BND_W'(xstp_pkg::NODES), "query bound out of tree")

endmodule
`default_nettype wire

/* rtl/core/xstp_ctrl.sv */
// controller: clear pass, toggle and query sequencing, output valid
`default_nettype none
`include "xor_segment_tree_parity_assert.svh"
module xstp_ctrl (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire                    s_valid,
    output logic                   s_ready,
    input  wire                    s_action,
    output logic                   m_valid,
    input  wire                    m_ready,
    input  wire xstp_pkg::dp_sts_t sts,
    output xstp_pkg::dp_cmd_t      cmd
);

    xstp_pkg::state_t state_reg;
    xstp_pkg::state_t state_next;
    logic             m_valid_reg;
    logic             m_valid_next;
    logic             out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            xstp_pkg::ST_CLEAR: begin
                if (sts.clear_last) begin
                    state_next = xstp_pkg::ST_IDLE;
                end
            end
            xstp_pkg::ST_IDLE: begin
                if (s_valid) begin
                    if (s_action == xstp_pkg::ACT_QUERY) begin
                        state_next = xstp_pkg::ST_QR_WALK;
                    end else if (sts.in_range) begin
                        state_next = xstp_pkg::ST_TG_LEAF;
                    end
                end
            end
            xstp_pkg::ST_TG_LEAF: begin
                state_next = xstp_pkg::ST_TG_WALK;
            end
            xstp_pkg::ST_TG_WALK: begin
                if (sts.tg_top) begin
                    state_next = xstp_pkg::ST_IDLE;
                end
            end
            xstp_pkg::ST_QR_WALK: begin
                if (!sts.qr_busy) begin
                    state_next = xstp_pkg::ST_QR_OUT;
                end
            end
            xstp_pkg::ST_QR_OUT: begin
                if (out_free) begin
                    state_next = xstp_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = xstp_pkg::ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            xstp_pkg::ST_CLEAR: begin
                cmd.clear_step = 1'b1;
            end
            xstp_pkg::ST_IDLE: begin
                s_ready         = 1'b1;
                cmd.load_toggle = s_valid && (s_action == xstp_pkg::ACT_TOGGLE) && sts.in_range;
                cmd.load_query  = s_valid && (s_action == xstp_pkg::ACT_QUERY);
            end
            xstp_pkg::ST_TG_LEAF: begin
                cmd.tg_leaf = 1'b1;
            end
            xstp_pkg::ST_TG_WALK: begin
                cmd.tg_walk = 1'b1;
            end
            xstp_pkg::ST_QR_WALK: begin
                cmd.qr_step = 1'b1;
            end
            xstp_pkg::ST_QR_OUT: begin
                cmd.load_out = out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    assign m_valid_next = cmd.load_out || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= xstp_pkg::ST_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

    `XSTP_ASSERT_SAME(a_no_accept_in_clear, aclk, aresetn,
        state_reg == xstp_pkg::ST_CLEAR, !s_ready, "input taken during clear pass")
    `XSTP_ASSERT_NEXT(a_query_starts_walk, aclk, aresetn,
        cmd.load_query, state_reg == xstp_pkg::ST_QR_WALK, "query did not start walk")
    `XSTP_ASSERT_NEXT(a_out_waits, aclk, aresetn,
        (state_reg == xstp_pkg::ST_QR_OUT) && m_valid_reg && !m_ready,
        (state_reg == xstp_pkg::ST_QR_OUT) && m_valid_reg, "result overwrote pending beat")

endmodule
`default_nettype wire
